FILE: hw/rtl/r2fft_pkg.sv
// ----------------------------------------------------------------------------
// r2fft_pkg
// Shared types and constants of the radix-2 DIF FFT engine.
// ----------------------------------------------------------------------------
package r2fft_pkg;

    localparam int DATA_W    = 24;
    localparam int SAMPLE_W  = 16;
    localparam int ROM_LOG2  = 6;
    localparam int CFG_W     = 3;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_SIZE_LOG2    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_INVERSE_MODE = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load_wr;    // write the input word into store A
        logic       bf_rd;      // read the butterfly operand pair
        logic       bf_wr;      // write the butterfly results
        logic       out_rd;     // read one bin from the final store
        logic       src_b;      // current source store is B
        logic [5:0] addr_a;     // upper operand index / load index / bin index
        logic [5:0] addr_b;     // lower operand index
        logic [4:0] tw_idx;     // twiddle index into the 64-point table
        logic [2:0] shift;      // transform length log2
        logic       inv;        // inverse mode
    } r2fft_cmd_t;

    // Q1.23 cosine quarter-wave, k = 0..16.
    function automatic logic [23:0] cos_q23(input logic [4:0] k);
        logic [23:0] v;
        case (k)
            5'd0:  v = 24'd8388608;
            5'd1:  v = 24'd8348215;
            5'd2:  v = 24'd8227423;
            5'd3:  v = 24'd8027397;
            5'd4:  v = 24'd7750063;
            5'd5:  v = 24'd7398092;
            5'd6:  v = 24'd6974873;
            5'd7:  v = 24'd6484482;
            5'd8:  v = 24'd5931642;
            5'd9:  v = 24'd5321677;
            5'd10: v = 24'd4660461;
            5'd11: v = 24'd3954362;
            5'd12: v = 24'd3210181;
            5'd13: v = 24'd2435084;
            5'd14: v = 24'd1636536;
            5'd15: v = 24'd822227;
            default: v = 24'd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [DATA_W-1:0] sat24(input logic signed [DATA_W+1:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > 26'sd8388607)
            r = 24'sd8388607;
        else if (v < -26'sd8388608)
            r = -24'sd8388608;
        else
            r = v[DATA_W-1:0];
        return r;
    endfunction

endpackage

FILE: hw/rtl/r2fft_datapath.sv
// ----------------------------------------------------------------------------
// r2fft_datapath
// Two work stores, a butterfly unit with a twiddle table, and the bin output.
// ----------------------------------------------------------------------------
module r2fft_datapath #(
    parameter int TWIDDLE_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  r2fft_pkg::r2fft_cmd_t               cmd,
    input  logic signed [r2fft_pkg::SAMPLE_W-1:0] sample_real,
    input  logic signed [r2fft_pkg::SAMPLE_W-1:0] sample_imag,
    output logic signed [r2fft_pkg::DATA_W-1:0]   rd_real,
    output logic signed [r2fft_pkg::DATA_W-1:0]   rd_imag
);

    localparam int DW  = r2fft_pkg::DATA_W;
    localparam int TW  = TWIDDLE_BITS;
    localparam int SH  = 24 - TW;
    localparam int PW  = DW + TW + 1;
    localparam logic signed [TW:0] TOP = (TW+1)'((1 << (TW-1)) - 1);

    logic [2*DW-1:0] store_a [64];
    logic [2*DW-1:0] store_b [64];

    logic [2*DW-1:0] rd_a_reg, rd_b_reg;
    logic            bf_v_reg;
    logic            bf1_v_reg;
    logic            bf2_v_reg;
    logic [5:0]      wa_reg, wb_reg, wa1_reg, wb1_reg, wa2_reg, wb2_reg;
    logic            dst_b_reg, dst1_b_reg, dst2_b_reg;
    logic [4:0]      tw_reg;
    logic signed [DW-1:0] sr_reg, si_reg, dr_reg, di_reg;
    logic signed [TW:0]   wr_reg, wi_reg;
    logic signed [PW-1:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg;
    logic signed [DW-1:0] s2r_reg, s2i_reg;

    // Twiddle magnitude rounded to the chosen precision.
    function automatic logic signed [TW:0] tw_mag(input logic [4:0] k);
        logic [24:0] v;
        logic signed [TW:0] r;
        v = {1'b0, r2fft_pkg::cos_q23(k)};
        if (SH > 0)
            v = (v + (25'd1 << (SH - 1))) >> SH;
        if ($signed({1'b0, v}) > $signed({{(25-TW){1'b0}}, TOP}))
            r = TOP;
        else
            r = (TW+1)'(v);
        return r;
    endfunction

    // Twiddle lookup for index m (0..31).
    logic signed [TW:0] w_re, w_im;
    always_comb
    begin
        if (tw_reg <= 5'd16)
        begin
            w_re = tw_mag(tw_reg);
            w_im = -tw_mag(5'd16 - tw_reg);
        end
        else
        begin
            w_re = -tw_mag(5'd0 - tw_reg);
            w_im = -tw_mag(tw_reg - 5'd16);
        end
    end

    // Memory read, load write and butterfly write-back.
    always_ff @(posedge clk)
    begin
        if (cmd.load_wr)
            store_a[cmd.addr_a] <= {DW'(sample_real), cmd.inv ? -DW'(sample_imag)
                                                             : DW'(sample_imag)};
        if (cmd.bf_rd || cmd.out_rd)
        begin
            rd_a_reg <= cmd.src_b ? store_b[cmd.addr_a] : store_a[cmd.addr_a];
            rd_b_reg <= cmd.src_b ? store_b[cmd.addr_b] : store_a[cmd.addr_b];
        end
        if (bf2_v_reg)
        begin
            if (dst2_b_reg)
            begin
                store_b[wa2_reg] <= {s2r_reg, s2i_reg};
                store_b[wb2_reg] <= {r2fft_pkg::sat24(26'(
                    (p_rr_reg - p_ii_reg + (PW'(1) <<< (TW-2))) >>> (TW-1))),
                    r2fft_pkg::sat24(26'(
                    (p_ri_reg + p_ir_reg + (PW'(1) <<< (TW-2))) >>> (TW-1)))};
            end
            else
            begin
                store_a[wa2_reg] <= {s2r_reg, s2i_reg};
                store_a[wb2_reg] <= {r2fft_pkg::sat24(26'(
                    (p_rr_reg - p_ii_reg + (PW'(1) <<< (TW-2))) >>> (TW-1))),
                    r2fft_pkg::sat24(26'(
                    (p_ri_reg + p_ir_reg + (PW'(1) <<< (TW-2))) >>> (TW-1)))};
            end
        end
    end

    // Butterfly stage one: sum, difference, twiddle.
    always_ff @(posedge clk)
    begin
        tw_reg <= cmd.tw_idx;
        wa_reg <= cmd.addr_a;
        wb_reg <= cmd.addr_b;
        dst_b_reg <= ~cmd.src_b;
        wa1_reg <= wa_reg;
        wb1_reg <= wb_reg;
        dst1_b_reg <= dst_b_reg;
        sr_reg <= r2fft_pkg::sat24(26'($signed(rd_a_reg[2*DW-1:DW])) +
                                   26'($signed(rd_b_reg[2*DW-1:DW])));
        si_reg <= r2fft_pkg::sat24(26'($signed(rd_a_reg[DW-1:0])) +
                                   26'($signed(rd_b_reg[DW-1:0])));
        dr_reg <= r2fft_pkg::sat24(26'($signed(rd_a_reg[2*DW-1:DW])) -
                                   26'($signed(rd_b_reg[2*DW-1:DW])));
        di_reg <= r2fft_pkg::sat24(26'($signed(rd_a_reg[DW-1:0])) -
                                   26'($signed(rd_b_reg[DW-1:0])));
        wr_reg <= w_re;
        wi_reg <= w_im;
        // Stage two: four products.
        wa2_reg <= wa1_reg;
        wb2_reg <= wb1_reg;
        dst2_b_reg <= dst1_b_reg;
        s2r_reg <= sr_reg;
        s2i_reg <= si_reg;
        p_rr_reg <= PW'(dr_reg) * PW'(wr_reg);
        p_ii_reg <= PW'(di_reg) * PW'(wi_reg);
        p_ri_reg <= PW'(dr_reg) * PW'(wi_reg);
        p_ir_reg <= PW'(di_reg) * PW'(wr_reg);
    end

    // Write-enable pipeline for the butterfly results.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bf_v_reg  <= 1'b0;
            bf1_v_reg <= 1'b0;
            bf2_v_reg <= 1'b0;
        end
        else
        begin
            bf_v_reg  <= cmd.bf_wr;
            bf1_v_reg <= bf_v_reg;
            bf2_v_reg <= bf1_v_reg;
        end
    end

    // Output bin; inverse mode conjugates and scales it.
    logic signed [DW:0] neg_im;
    always_comb
    begin
        neg_im = -(DW+1)'($signed(rd_a_reg[DW-1:0]));
        if (cmd.inv)
        begin
            rd_real = DW'($signed(rd_a_reg[2*DW-1:DW]) >>> cmd.shift);
            rd_imag = DW'(neg_im >>> cmd.shift);
        end
        else
        begin
            rd_real = $signed(rd_a_reg[2*DW-1:DW]);
            rd_imag = $signed(rd_a_reg[DW-1:0]);
        end
    end

endmodule

FILE: hw/rtl/r2fft_ctrl.sv
// ----------------------------------------------------------------------------
// r2fft_ctrl
// Sequencer: load, butterfly stages, bit-reversed unload with output register.
// ----------------------------------------------------------------------------
module r2fft_ctrl #(
    parameter int MAX_POINTS = 64
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic [r2fft_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [r2fft_pkg::CFG_W-1:0]          cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 last_bin,
    output logic                                 out_load,
    output r2fft_pkg::r2fft_cmd_t                cmd
);

    localparam int MAXL = (MAX_POINTS >= 64) ? 6 : $clog2(MAX_POINTS + 1) - 1;

    typedef enum logic [2:0] {ST_LOAD, ST_BFLY, ST_DRAIN, ST_READ, ST_WAIT, ST_OUT} state_t;

    state_t     state_reg;
    logic [2:0] size_reg;
    logic       inv_reg;
    logic [6:0] cnt_reg;
    logic [2:0] stage_reg;
    logic [5:0] bf_reg;
    logic       src_b_reg;
    logic [1:0] drain_reg;
    logic       out_v_reg, last_reg;

    logic [2:0] lval;
    logic [6:0] npts;
    logic [5:0] half, jbase, ipos, rev;
    logic [2:0] hl;
    always_comb
    begin
        lval = size_reg;
        if (lval > 3'(MAXL))
            lval = 3'(MAXL);
        if (lval == 3'd0)
            lval = 3'd1;
        npts = 7'd1 << lval;
        hl   = lval - 3'd1 - stage_reg;
        half = 6'd1 << hl;
        ipos = bf_reg & (half - 6'd1);
        jbase = (bf_reg & ~(half - 6'd1)) << 1;
        rev = 6'd0;
        for (int i = 0; i < 6; i++)
            if (3'(i) < lval)
                rev[lval - 3'd1 - 3'(i)] = cnt_reg[i];
    end

    assign in_ready  = (state_reg == ST_LOAD);
    assign out_valid = out_v_reg;
    assign last_bin  = last_reg;

    always_comb
    begin
        cmd         = '0;
        cmd.shift   = lval;
        cmd.inv     = inv_reg;
        cmd.src_b   = src_b_reg;
        cmd.load_wr = in_valid && in_ready;
        case (state_reg)
            ST_LOAD:
            begin
                cmd.addr_a = cnt_reg[5:0];
            end
            ST_BFLY:
            begin
                cmd.bf_rd  = 1'b1;
                cmd.bf_wr  = 1'b1;
                cmd.addr_a = jbase + ipos;
                cmd.addr_b = jbase + ipos + half;
                cmd.tw_idx = 5'((ipos << stage_reg) << (3'd6 - lval));
            end
            ST_READ:
            begin
                cmd.out_rd = 1'b1;
                cmd.addr_a = rev;
            end
            default:
            begin
                cmd.addr_a = '0;
            end
        endcase
    end

    assign out_load = (state_reg == ST_WAIT);

    // State machine and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            size_reg  <= 3'd6;
            inv_reg   <= 1'b0;
            cnt_reg   <= '0;
            stage_reg <= '0;
            bf_reg    <= '0;
            src_b_reg <= 1'b0;
            drain_reg <= '0;
            out_v_reg <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                cnt_reg <= '0;
                if (cfg_index == r2fft_pkg::REG_SIZE_LOG2)
                    size_reg <= cfg_data;
                else
                    inv_reg <= cfg_data[0];
            end
            if (out_v_reg && out_ready)
                out_v_reg <= 1'b0;
            unique case (state_reg)
                ST_LOAD:
                begin
                    if (in_valid && !cfg_wr_en)
                    begin
                        if (cnt_reg + 7'd1 == npts)
                        begin
                            cnt_reg   <= '0;
                            stage_reg <= '0;
                            bf_reg    <= '0;
                            src_b_reg <= 1'b0;
                            state_reg <= ST_BFLY;
                        end
                        else
                            cnt_reg <= cnt_reg + 7'd1;
                    end
                end
                ST_BFLY:
                begin
                    if (bf_reg == 6'((npts >> 1) - 7'd1))
                    begin
                        bf_reg    <= '0;
                        drain_reg <= '0;
                        state_reg <= ST_DRAIN;
                    end
                    else
                        bf_reg <= bf_reg + 6'd1;
                end
                ST_DRAIN:
                begin
                    // Let the last butterfly write back before the next stage or the unload.
                    drain_reg <= drain_reg + 2'd1;
                    if (drain_reg == 2'd3)
                    begin
                        src_b_reg <= ~src_b_reg;
                        if (stage_reg == lval - 3'd1)
                        begin
                            cnt_reg   <= '0;
                            state_reg <= ST_READ;
                        end
                        else
                        begin
                            stage_reg <= stage_reg + 3'd1;
                            state_reg <= ST_BFLY;
                        end
                    end
                end
                ST_READ:
                begin
                    state_reg <= ST_WAIT;
                end
                ST_WAIT:
                begin
                    state_reg <= ST_OUT;
                    out_v_reg <= 1'b1;
                    last_reg  <= (cnt_reg + 7'd1 == npts);
                end
                ST_OUT:
                begin
                    if (out_ready)
                    begin
                        if (cnt_reg + 7'd1 == npts)
                        begin
                            cnt_reg   <= '0;
                            state_reg <= ST_LOAD;
                        end
                        else
                        begin
                            cnt_reg   <= cnt_reg + 7'd1;
                            state_reg <= ST_READ;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

endmodule

FILE: hw/rtl/radix2_fft_engine_unit.sv
// ----------------------------------------------------------------------------
// radix2_fft_engine_unit
// Radix-2 decimation-in-frequency FFT/IFFT over frames of up to 64 points.
// ----------------------------------------------------------------------------
//  Channel | Signals                              | Direction
//  input   | in_valid, in_ready, sample_*         | one sample word per beat
//  output  | out_valid, out_ready, bin_*, last_bin| one bin word per beat
//  config  | cfg_wr_en, cfg_index, cfg_data       | register write, no wait
//
// A frame of N samples loads at one word a cycle while words are offered. Each
// of log2 N stages runs N/2 butterflies through one butterfly unit at one a
// cycle, then a pipeline drain. Unload reads the store in bit-reversed order,
// each bin once the last is taken. Reset leaves the engine ready to load.
// ----------------------------------------------------------------------------
module radix2_fft_engine_unit #(
    parameter int MAX_POINTS   = 64,
    parameter int TWIDDLE_BITS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic [r2fft_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [r2fft_pkg::CFG_W-1:0]          cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [r2fft_pkg::SAMPLE_W-1:0] sample_real,
    input  logic signed [r2fft_pkg::SAMPLE_W-1:0] sample_imag,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [r2fft_pkg::DATA_W-1:0]  bin_real,
    output logic signed [r2fft_pkg::DATA_W-1:0]  bin_imag,
    output logic                                 last_bin
);

    r2fft_pkg::r2fft_cmd_t cmd;
    logic out_load;
    logic signed [r2fft_pkg::DATA_W-1:0] rd_real, rd_imag;
    logic signed [r2fft_pkg::DATA_W-1:0] bre_reg, bim_reg;

    r2fft_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .out_valid(out_valid), .out_ready(out_ready), .last_bin(last_bin),
        .out_load(out_load), .cmd(cmd)
    );

    r2fft_datapath #(.TWIDDLE_BITS(TWIDDLE_BITS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd),
        .sample_real(sample_real), .sample_imag(sample_imag),
        .rd_real(rd_real), .rd_imag(rd_imag)
    );

    // Output word register.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            bre_reg <= rd_real;
            bim_reg <= rd_imag;
        end
    end

    assign bin_real = bre_reg;
    assign bin_imag = bim_reg;

endmodule

FILE: tb/tb_radix2_fft_engine_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_radix2_fft_engine_unit
// Self-checking bench for the radix-2 DIF FFT/IFFT engine. Frames of samples
// are sent over several length and direction settings. Each frame is also
// transformed here in fixed point, and every bin word from the engine is
// checked against the expected bins in order. Both channels stall at random.
// ----------------------------------------------------------------------------
module tb_radix2_fft_engine_unit;

    typedef struct {
        logic signed [r2fft_pkg::SAMPLE_W-1:0] re;
        logic signed [r2fft_pkg::SAMPLE_W-1:0] im;
    } sample_t;

    typedef struct {
        logic signed [r2fft_pkg::DATA_W-1:0] re;
        logic signed [r2fft_pkg::DATA_W-1:0] im;
        logic                                last;
    } bin_t;

    // Q1.23 cosine quarter wave, index 0..16.
    localparam longint COS_Q23 [17] = '{
        8388608, 8348215, 8227423, 8027397, 7750063, 7398092, 6974873, 6484482,
        5931642, 5321677, 4660461, 3954362, 3210181, 2435084, 1636536, 822227, 0
    };
    localparam int TW_BITS = 16;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [r2fft_pkg::CFG_IDX_W-1:0] cfg_index = r2fft_pkg::REG_SIZE_LOG2;
    logic [r2fft_pkg::CFG_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [r2fft_pkg::SAMPLE_W-1:0] sample_real = '0;
    logic signed [r2fft_pkg::SAMPLE_W-1:0] sample_imag = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [r2fft_pkg::DATA_W-1:0] bin_real;
    logic signed [r2fft_pkg::DATA_W-1:0] bin_imag;
    logic last_bin;

    sample_t pending_samples[$];
    bin_t    expected_bins[$];
    int      error_count = 0;
    int      cycle_count = 0;
    logic    quiet;

    // Predictor state: register copies and the frame being loaded.
    int      size_reg = 6;
    int      inv_reg = 0;
    int      load_cnt = 0;
    longint  frame_re[64];
    longint  frame_im[64];

    radix2_fft_engine_unit u_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .sample_real(sample_real), .sample_imag(sample_imag),
        .out_valid(out_valid), .out_ready(out_ready),
        .bin_real(bin_real), .bin_imag(bin_imag), .last_bin(last_bin)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // A long window without any idling comes around every so often.
    assign quiet = ((cycle_count / 1500) % 4) == 1;

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    function automatic int frame_log2();
        int l;
        l = size_reg;
        if (l > 6) l = 6;
        if (l < 1) l = 1;
        return l;
    endfunction

    function automatic longint clamp24(longint v);
        if (v > 64'sd8388607) return 64'sd8388607;
        if (v < -64'sd8388608) return -64'sd8388608;
        return v;
    endfunction

    function automatic longint twiddle_mag(int k);
        longint v;
        v = (COS_Q23[k] + (64'sd1 << (23 - TW_BITS))) >>> (24 - TW_BITS);
        if (v > (64'sd1 << (TW_BITS - 1)) - 1) v = (64'sd1 << (TW_BITS - 1)) - 1;
        return v;
    endfunction

    function automatic longint round_product(longint p);
        return clamp24((p + (64'sd1 << (TW_BITS - 2))) >>> (TW_BITS - 1));
    endfunction

    // Full DIF transform of the loaded frame; bins go out in natural order.
    function automatic void transform_frame();
        longint sr[64], si[64], dr[64], di[64];
        longint xr, xi, wr, wi;
        int l, n, k, j, i, span, half, m, r;
        bin_t b;
        l = frame_log2();
        n = 1 << l;
        sr = frame_re;
        si = frame_im;
        dr = frame_re;
        di = frame_im;
        for (k = 0; k < l; k++)
        begin
            span = 1 << (l - k);
            half = span >> 1;
            for (j = 0; j < n; j += span)
            begin
                for (i = 0; i < half; i++)
                begin
                    m = ((i << k) << (6 - l)) & 31;
                    if (m <= 16)
                    begin
                        wr = twiddle_mag(m);
                        wi = -twiddle_mag(16 - m);
                    end
                    else
                    begin
                        wr = -twiddle_mag(32 - m);
                        wi = -twiddle_mag(m - 16);
                    end
                    xr = clamp24(sr[j+i] - sr[j+i+half]);
                    xi = clamp24(si[j+i] - si[j+i+half]);
                    dr[j+i] = clamp24(sr[j+i] + sr[j+i+half]);
                    di[j+i] = clamp24(si[j+i] + si[j+i+half]);
                    dr[j+i+half] = round_product(xr * wr - xi * wi);
                    di[j+i+half] = round_product(xr * wi + xi * wr);
                end
            end
            sr = dr;
            si = di;
        end
        for (j = 0; j < n; j++)
        begin
            r = 0;
            for (i = 0; i < l; i++)
                if (j & (1 << i)) r |= 1 << (l - 1 - i);
            xr = sr[r];
            xi = si[r];
            if (inv_reg != 0)
            begin
                xr = xr >>> l;
                xi = (-xi) >>> l;
            end
            b.re = xr[r2fft_pkg::DATA_W-1:0];
            b.im = xi[r2fft_pkg::DATA_W-1:0];
            b.last = (j == n - 1);
            expected_bins.push_back(b);
        end
    endfunction

    // Sample word driver; accepted words are loaded into the predictor frame.
    always @(posedge clk or negedge rst_n)
    begin
        sample_t s;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                frame_re[load_cnt] = sample_real;
                frame_im[load_cnt] = (inv_reg != 0) ? -longint'(sample_imag)
                                                    : longint'(sample_imag);
                load_cnt = load_cnt + 1;
                if (load_cnt >= (1 << frame_log2()))
                begin
                    load_cnt = 0;
                    transform_frame();
                end
            end
            if (!in_valid || in_ready)
            begin
                if (pending_samples.size() > 0 && (quiet || $urandom_range(0, 99) >= 25))
                begin
                    s = pending_samples.pop_front();
                    in_valid <= 1'b1;
                    sample_real <= s.re;
                    sample_imag <= s.im;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Bin word monitor with random back-pressure.
    always @(posedge clk or negedge rst_n)
    begin
        bin_t e;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_bins.size() == 0)
                begin
                    $display("%0t: unexpected bin word re=%0d im=%0d last=%0b",
                             $realtime, bin_real, bin_imag, last_bin);
                    error_count++;
                end
                else
                begin
                    e = expected_bins.pop_front();
                    if (bin_real !== e.re || bin_imag !== e.im || last_bin !== e.last)
                    begin
                        $display("%0t: bin mismatch expected re=%0d im=%0d last=%0b",
                                 $realtime, e.re, e.im, e.last);
                        $display("%0t:              actual re=%0d im=%0d last=%0b",
                                 $realtime, bin_real, bin_imag, last_bin);
                        error_count++;
                    end
                end
            end
            out_ready <= quiet || ($urandom_range(0, 99) >= 25);
        end
    end

    function automatic logic signed [r2fft_pkg::SAMPLE_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 16'sh7fff;
            1: return -16'sh8000;
            2: return 16'sh0000;
            default: return r2fft_pkg::SAMPLE_W'($urandom());
        endcase
    endfunction

    // Frame kinds: random, all positive full scale, all negative full scale,
    // alternating full scale, and a single impulse.
    task automatic queue_frame(input int kind, input int count);
        sample_t s;
        int i;
        for (i = 0; i < count; i++)
        begin
            case (kind)
                1: begin s.re = 16'sh7fff; s.im = 16'sh7fff; end
                2: begin s.re = -16'sh8000; s.im = -16'sh8000; end
                3: begin
                    s.re = i[0] ? -16'sh8000 : 16'sh7fff;
                    s.im = i[0] ? 16'sh7fff : -16'sh8000;
                end
                4: begin s.re = (i == 0) ? 16'sh7fff : 16'sh0; s.im = '0; end
                default: begin s.re = pick_value(); s.im = pick_value(); end
            endcase
            pending_samples.push_back(s);
        end
    endtask

    task automatic write_reg(input logic [r2fft_pkg::CFG_IDX_W-1:0] idx, input int value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[r2fft_pkg::CFG_W-1:0];
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        if (idx == r2fft_pkg::REG_SIZE_LOG2)
            size_reg = value & 7;
        else
            inv_reg = value & 1;
        load_cnt = 0;
    endtask

    // Wait until every word is sent and every bin has come back.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_samples.size() > 0 || in_valid || expected_bins.size() > 0);
        repeat (100) @(posedge clk);
    endtask

    task automatic run_setting(input int lg, input int inv, input int frames,
                               input int kind, input int leftover);
        int n, f;
        write_reg(r2fft_pkg::REG_SIZE_LOG2, lg);
        write_reg(r2fft_pkg::REG_INVERSE_MODE, inv);
        n = 1 << frame_log2();
        for (f = 0; f < frames; f++)
            queue_frame(kind, n);
        // A partial frame is left behind to be dropped by the next write.
        queue_frame(0, leftover);
        wait_drained();
    endtask

    initial
    begin
        int r;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed frames at full scale.
        run_setting(2, 0, 1, 1, 0);
        run_setting(2, 0, 1, 2, 0);
        run_setting(2, 0, 1, 3, 0);
        run_setting(1, 1, 1, 2, 0);
        run_setting(1, 1, 1, 3, 1);
        run_setting(0, 0, 1, 4, 0);
        run_setting(7, 1, 0, 0, 0);

        // Random frames over many settings, mostly short lengths.
        run_setting(6, 0, 1, 0, 5);
        run_setting(6, 1, 1, 0, 0);
        run_setting(7, 0, 0, 0, 3);
        for (r = 0; r < 4; r++)
            run_setting($urandom_range(0, 4), $urandom_range(0, 1),
                        $urandom_range(1, 3), 0, $urandom_range(0, 2));
        run_setting(4, 1, 1, 0, 0);
        run_setting(1, 0, 6, 0, 1);

        wait_drained();
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("simulation failed");
        $finish;
    end

endmodule

FILE: radix2_fft_engine_unit.f
hw/rtl/r2fft_pkg.sv
hw/rtl/r2fft_datapath.sv
hw/rtl/r2fft_ctrl.sv
hw/rtl/radix2_fft_engine_unit.sv
tb/tb_radix2_fft_engine_unit.sv
